FILE: sv/tcce_pkg.sv
// Shared types, constants and helper functions of the text console cursor engine.
package tcce_pkg;

    localparam int POS_W    = 13;
    localparam int EDGE_W   = POS_W + 1;
    localparam int CODE_W   = 8;
    localparam int RGB_W    = 24;
    localparam int SCALE_W  = 3;
    localparam int CELL_W   = 6;
    localparam int EDGE_IN_W = 12;
    localparam int CFG_W    = 24;
    localparam int IDX_W    = 3;

    localparam int TAB_SPACES = 4;
    localparam int TAB_CW     = $clog2(TAB_SPACES + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_IW = $clog2(POS_W);

    localparam logic [CODE_W-1:0] CHAR_BS    = 8'd8;
    localparam logic [CODE_W-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CODE_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CODE_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CODE_W-1:0] CHAR_SPACE = 8'd32;

    localparam logic [EDGE_IN_W-1:0] RST_LEFT   = 12'd0;
    localparam logic [EDGE_IN_W-1:0] RST_TOP    = 12'd0;
    localparam logic [POS_W-1:0]     RST_WIDTH  = 13'd1920;
    localparam logic [POS_W-1:0]     RST_HEIGHT = 13'd1080;
    localparam logic [SCALE_W-1:0]   RST_SCALE  = 3'd2;
    localparam logic [RGB_W-1:0]     RST_FORE   = 24'h55FF55;
    localparam logic [RGB_W-1:0]     RST_BACK   = 24'h000000;

    typedef enum logic [IDX_W-1:0] {
        CFG_LEFT   = 3'd0,
        CFG_TOP    = 3'd1,
        CFG_WIDTH  = 3'd2,
        CFG_HEIGHT = 3'd3,
        CFG_SCALE  = 3'd4,
        CFG_FORE   = 3'd5,
        CFG_BACK   = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_GLYPH  = 2'd0,
        OP_CELL   = 2'd1,
        OP_SCROLL = 2'd2,
        OP_REGION = 2'd3
    } draw_op_t;

    typedef enum logic [2:0] {
        KIND_PUT   = 3'd0,
        KIND_CLEAR = 3'd1,
        KIND_CR    = 3'd2,
        KIND_LF    = 3'd3,
        KIND_TAB   = 3'd4,
        KIND_BS    = 3'd5
    } kind_t;

    typedef struct packed {
        logic [EDGE_IN_W-1:0] left;
        logic [EDGE_IN_W-1:0] top;
        logic [POS_W-1:0]     width;
        logic [POS_W-1:0]     height;
        logic [SCALE_W-1:0]   scale;
        logic [RGB_W-1:0]     fore;
        logic [RGB_W-1:0]     back;
    } cfg_t;

    typedef struct packed {
        logic                ready;
        logic [CELL_W-1:0]   cw;
        logic [CELL_W-1:0]   ch;
        logic [POS_W-1:0]    left;
        logic [POS_W-1:0]    top;
        logic [EDGE_W-1:0]   right;
        logic [EDGE_W-1:0]   bottom;
        logic [POS_W-1:0]    left_cw;
        logic [POS_W-1:0]    top_ch;
        logic [POS_W-1:0]    scroll_row;
        logic [POS_W-1:0]    bs_x;
        logic [RGB_W-1:0]    fore;
        logic [RGB_W-1:0]    back;
    } geom_t;

    typedef struct packed {
        kind_t             kind;
        logic [CODE_W-1:0] code;
    } q_entry_t;

    typedef struct packed {
        draw_op_t          op;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [CODE_W-1:0] glyph;
        logic [RGB_W-1:0]  ink;
        logic [RGB_W-1:0]  paper;
    } result_t;

    // Zero scale behaves as one.
    function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
        return (s == '0) ? SCALE_W'(1) : s;
    endfunction

    function automatic logic [CELL_W-1:0] cell_w(input logic [SCALE_W-1:0] s);
        logic [SCALE_W-1:0] e;
        e = eff_scale(s);
        return CELL_W'({e, 2'b00}) + CELL_W'({e, 1'b0});
    endfunction

    function automatic logic [CELL_W-1:0] cell_h(input logic [SCALE_W-1:0] s);
        logic [SCALE_W-1:0] e;
        e = eff_scale(s);
        return CELL_W'({e, 3'b000}) + CELL_W'(e);
    endfunction

endpackage

FILE: sv/tcce_if.sv
// Stream interfaces for the character input and the drawing command output.
interface tcce_text_if import tcce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [CODE_W-1:0] char_code;

    modport source (output valid, cmd, char_code, input ready);
    modport sink   (input valid, cmd, char_code, output ready);
endinterface

interface tcce_draw_if import tcce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        draw_op;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CODE_W-1:0] glyph_code;
    logic [RGB_W-1:0]  ink_rgb;
    logic [RGB_W-1:0]  paper_rgb;
    logic              last_of_run;

    modport source (output valid, draw_op, pos_x, pos_y, glyph_code, ink_rgb, paper_rgb,
                    last_of_run, input ready);
    modport sink   (input valid, draw_op, pos_x, pos_y, glyph_code, ink_rgb, paper_rgb,
                    last_of_run, output ready);
endinterface

FILE: sv/tcce_front.sv
// Input stage: accept a transaction, classify it and hand it to the queue.
module tcce_front import tcce_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    tcce_text_if.sink    text,
    output logic         push_valid,
    output q_entry_t     push_entry,
    input  logic         push_ready
);

    logic     st_valid_reg;
    logic     st_valid_next;
    q_entry_t st_entry_reg;
    kind_t    kind;
    logic     accept;

    always_comb
    begin
        if (text.cmd)
        begin
            kind = KIND_CLEAR;
        end
        else
        begin
            unique case (text.char_code)
                CHAR_CR:  kind = KIND_CR;
                CHAR_LF:  kind = KIND_LF;
                CHAR_TAB: kind = KIND_TAB;
                CHAR_BS:  kind = KIND_BS;
                default:  kind = KIND_PUT;
            endcase
        end
    end

    assign text.ready = !st_valid_reg || push_ready;
    assign accept     = text.valid && text.ready;

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (accept)
        begin
            st_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_entry_reg <= '{kind: kind, code: text.char_code};
        end
    end

    assign push_valid = st_valid_reg;
    assign push_entry = st_entry_reg;

endmodule

FILE: sv/tcce_queue.sv
// Short queue between the classifier and the command sequencer.
module tcce_queue import tcce_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    input  q_entry_t push_entry,
    output logic     push_ready,
    output logic     pop_valid,
    output q_entry_t pop_entry,
    input  logic     pop_ready
);

    q_entry_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg;
    logic [QUEUE_CW-1:0]   count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: sv/tcce_geom.sv
// Region geometry derived from the configuration, with a bit-serial remainder for the last column.
module tcce_geom import tcce_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  restart,
    output geom_t geom
);

    typedef enum logic [3:0] {
        G_DIV  = 4'b0001,
        G_FIN1 = 4'b0010,
        G_FIN2 = 4'b0100,
        G_DONE = 4'b1000
    } geom_state_t;

    geom_state_t        gst_reg;
    geom_state_t        gst_next;
    logic [DIV_IW-1:0]  idx_reg;
    logic [DIV_IW-1:0]  idx_next;
    logic [CELL_W-1:0]  rem_reg;
    logic [CELL_W-1:0]  rem_next;
    logic [POS_W-1:0]   last_off_reg;
    logic [POS_W-1:0]   bs_x_reg;

    logic [CELL_W-1:0]  cw;
    logic [CELL_W-1:0]  ch;
    logic [CELL_W:0]    trial;
    logic [CELL_W:0]    trial_sub;
    logic [POS_W:0]     off_sub;
    logic [POS_W-1:0]   bs_off;

    logic [CELL_W-1:0]  cw_reg;
    logic [CELL_W-1:0]  ch_reg;
    logic [POS_W-1:0]   left_reg;
    logic [POS_W-1:0]   top_reg;
    logic [EDGE_W-1:0]  right_reg;
    logic [EDGE_W-1:0]  bottom_reg;
    logic [POS_W-1:0]   left_cw_reg;
    logic [POS_W-1:0]   top_ch_reg;
    logic [POS_W-1:0]   scroll_row_reg;
    logic [RGB_W-1:0]   fore_reg;
    logic [RGB_W-1:0]   back_reg;

    assign cw = cell_w(cfg.scale);
    assign ch = cell_h(cfg.scale);

    // One quotient bit per cycle, most significant width bit first.
    assign trial     = {rem_reg, cfg.width[idx_reg]};
    assign trial_sub = trial - {1'b0, cw};
    assign off_sub   = {1'b0, last_off_reg} - (POS_W + 1)'(cw);
    assign bs_off    = off_sub[POS_W] ? last_off_reg : off_sub[POS_W-1:0];

    always_comb
    begin
        gst_next = gst_reg;
        idx_next = idx_reg;
        rem_next = rem_reg;
        if (restart)
        begin
            gst_next = G_DIV;
            idx_next = DIV_IW'(POS_W - 1);
            rem_next = '0;
        end
        else
        begin
            unique case (gst_reg)
                G_DIV:
                begin
                    rem_next = trial_sub[CELL_W] ? trial[CELL_W-1:0] : trial_sub[CELL_W-1:0];
                    if (idx_reg == '0)
                    begin
                        gst_next = G_FIN1;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
                G_FIN1:  gst_next = G_FIN2;
                G_FIN2:  gst_next = G_DONE;
                G_DONE:  gst_next = G_DONE;
                default: gst_next = G_DIV;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gst_reg <= G_DIV;
            idx_reg <= DIV_IW'(POS_W - 1);
            rem_reg <= '0;
        end
        else
        begin
            gst_reg <= gst_next;
            idx_reg <= idx_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gst_reg == G_FIN1)
        begin
            last_off_reg <= cfg.width - POS_W'(rem_reg);
        end
        if (gst_reg == G_FIN2)
        begin
            bs_x_reg <= {1'b0, cfg.left} + bs_off;
        end
        cw_reg         <= cw;
        ch_reg         <= ch;
        left_reg       <= {1'b0, cfg.left};
        top_reg        <= {1'b0, cfg.top};
        right_reg      <= EDGE_W'(cfg.left) + EDGE_W'(cfg.width);
        bottom_reg     <= EDGE_W'(cfg.top) + EDGE_W'(cfg.height);
        left_cw_reg    <= POS_W'(cfg.left) + POS_W'(cw);
        top_ch_reg     <= POS_W'(cfg.top) + POS_W'(ch);
        scroll_row_reg <= POS_W'(cfg.top) + cfg.height - POS_W'(ch);
        fore_reg       <= cfg.fore;
        back_reg       <= cfg.back;
    end

    assign geom = '{
        ready:      (gst_reg == G_DONE),
        cw:         cw_reg,
        ch:         ch_reg,
        left:       left_reg,
        top:        top_reg,
        right:      right_reg,
        bottom:     bottom_reg,
        left_cw:    left_cw_reg,
        top_ch:     top_ch_reg,
        scroll_row: scroll_row_reg,
        bs_x:       bs_x_reg,
        fore:       fore_reg,
        back:       back_reg
    };

endmodule

FILE: sv/tcce_back.sv
// Command sequencer: cursor state, wrap and scroll steps, and the result output stage.
module tcce_back import tcce_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  geom_t       geom,
    input  logic        pop_valid,
    input  q_entry_t    pop_entry,
    output logic        pop_ready,
    tcce_draw_if.source draw
);

    typedef enum logic [3:0] {
        B_FETCH = 4'b0001,
        B_WRAP1 = 4'b0010,
        B_GLYPH = 4'b0100,
        B_WRAP2 = 4'b1000
    } back_state_t;

    back_state_t        bst_reg;
    back_state_t        bst_next;
    back_state_t        bst_step;
    logic [POS_W-1:0]   col_reg;
    logic [POS_W-1:0]   col_next;
    logic [POS_W-1:0]   col_step;
    logic [POS_W-1:0]   row_reg;
    logic [POS_W-1:0]   row_next;
    logic [POS_W-1:0]   row_step;
    logic [CODE_W-1:0]  code_reg;
    logic [CODE_W-1:0]  code_step;
    logic [TAB_CW-1:0]  spaces_reg;
    logic [TAB_CW-1:0]  spaces_next;
    logic [TAB_CW-1:0]  spaces_step;

    logic               p_valid_reg;
    logic               p_valid_next;
    logic               p_final_reg;
    logic               p_final_next;
    result_t            p_res_reg;
    logic               o_valid_reg;
    logic               o_valid_next;
    logic               o_last_reg;
    result_t            o_res_reg;

    logic [EDGE_W-1:0]  col_cw;
    logic [EDGE_W-1:0]  row_ch;
    logic [POS_W-1:0]   row_ch_m;
    logic [EDGE_W-1:0]  row_2;
    logic               wrap;
    logic               scroll;
    logic [POS_W-1:0]   w_col;
    logic [POS_W-1:0]   w_row;
    logic [POS_W-1:0]   bs_col;
    logic [POS_W-1:0]   bs_row;
    result_t            scroll_res;

    logic               st_active;
    logic               st_res_valid;
    logic               st_final;
    result_t            st_res;
    logic               fire;
    logic               new_res;
    logic               out_load;
    logic               push_now;

    // Wrap check: past the right edge goes to the next row, past the bottom scrolls.
    assign col_cw   = EDGE_W'(col_reg) + EDGE_W'(geom.cw);
    assign wrap     = (col_cw > geom.right);
    assign row_ch   = EDGE_W'(row_reg) + EDGE_W'(geom.ch);
    assign row_ch_m = row_ch[POS_W-1:0];
    assign row_2    = EDGE_W'(row_ch_m) + EDGE_W'(geom.ch);
    assign scroll   = wrap ? (row_2 > geom.bottom) : (row_ch > geom.bottom);
    assign w_col    = wrap ? geom.left : col_reg;
    assign w_row    = scroll ? geom.scroll_row : (wrap ? row_ch_m : row_reg);

    // Backspace: step left, or to the last cell of the row above, or stay.
    always_comb
    begin
        bs_col = col_reg;
        bs_row = row_reg;
        if (col_reg >= geom.left_cw)
        begin
            bs_col = col_reg - POS_W'(geom.cw);
        end
        else if (row_reg >= geom.top_ch)
        begin
            bs_row = row_reg - POS_W'(geom.ch);
            bs_col = geom.bs_x;
        end
    end

    assign scroll_res = '{op: OP_SCROLL, x: geom.left, y: geom.top, glyph: '0, ink: '0,
                          paper: geom.back};

    always_comb
    begin
        st_active    = 1'b0;
        st_res_valid = 1'b0;
        st_final     = 1'b0;
        st_res       = scroll_res;
        col_step     = col_reg;
        row_step     = row_reg;
        bst_step     = bst_reg;
        code_step    = code_reg;
        spaces_step  = spaces_reg;
        unique case (bst_reg)
            B_FETCH:
            begin
                st_active = pop_valid && geom.ready;
                unique case (pop_entry.kind)
                    KIND_CLEAR:
                    begin
                        col_step     = geom.left;
                        row_step     = geom.top;
                        st_res_valid = 1'b1;
                        st_res.op    = OP_REGION;
                        st_final     = 1'b1;
                    end
                    KIND_CR:
                    begin
                        col_step = geom.left;
                        st_final = 1'b1;
                    end
                    KIND_LF:
                    begin
                        col_step    = geom.left;
                        row_step    = row_ch_m;
                        spaces_step = '0;
                        bst_step    = B_WRAP2;
                    end
                    KIND_BS:
                    begin
                        col_step     = bs_col;
                        row_step     = bs_row;
                        st_res_valid = 1'b1;
                        st_res.op    = OP_CELL;
                        st_res.x     = bs_col;
                        st_res.y     = bs_row;
                        st_final     = 1'b1;
                    end
                    KIND_TAB:
                    begin
                        col_step     = w_col;
                        row_step     = w_row;
                        st_res_valid = scroll;
                        code_step    = CHAR_SPACE;
                        spaces_step  = TAB_CW'(TAB_SPACES - 1);
                        bst_step     = B_GLYPH;
                    end
                    default:
                    begin
                        col_step     = w_col;
                        row_step     = w_row;
                        st_res_valid = scroll;
                        code_step    = pop_entry.code;
                        spaces_step  = '0;
                        bst_step     = B_GLYPH;
                    end
                endcase
            end
            B_WRAP1:
            begin
                st_active    = 1'b1;
                col_step     = w_col;
                row_step     = w_row;
                st_res_valid = scroll;
                bst_step     = B_GLYPH;
            end
            B_GLYPH:
            begin
                st_active    = 1'b1;
                st_res_valid = 1'b1;
                st_res.op    = OP_GLYPH;
                st_res.x     = col_reg;
                st_res.y     = row_reg;
                st_res.glyph = code_reg;
                st_res.ink   = geom.fore;
                col_step     = col_reg + POS_W'(geom.cw);
                bst_step     = B_WRAP2;
            end
            B_WRAP2:
            begin
                st_active    = 1'b1;
                col_step     = w_col;
                row_step     = w_row;
                st_res_valid = scroll;
                if (spaces_reg == '0)
                begin
                    st_final = 1'b1;
                    bst_step = B_FETCH;
                end
                else
                begin
                    spaces_step = spaces_reg - 1'b1;
                    bst_step    = B_WRAP1;
                end
            end
            default:
            begin
                bst_step = B_FETCH;
            end
        endcase
    end

    // The pending result waits until the next result or the end of the item
    // tells whether it closes the run.
    assign out_load  = !o_valid_reg || draw.ready;
    assign fire      = st_active && (!st_res_valid || !p_valid_reg || out_load);
    assign new_res   = fire && st_res_valid;
    assign push_now  = p_valid_reg && out_load && (p_final_reg || new_res);
    assign pop_ready = fire && (bst_reg == B_FETCH);

    always_comb
    begin
        bst_next    = fire ? bst_step : bst_reg;
        col_next    = fire ? col_step : col_reg;
        row_next    = fire ? row_step : row_reg;
        spaces_next = fire ? spaces_step : spaces_reg;

        p_valid_next = p_valid_reg;
        p_final_next = p_final_reg;
        if (new_res)
        begin
            p_valid_next = 1'b1;
            p_final_next = st_final;
        end
        else
        begin
            if (push_now)
            begin
                p_valid_next = 1'b0;
            end
            if (fire && st_final && p_valid_reg)
            begin
                p_final_next = 1'b1;
            end
        end

        o_valid_next = o_valid_reg;
        if (push_now)
        begin
            o_valid_next = 1'b1;
        end
        else if (draw.ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bst_reg     <= B_FETCH;
            col_reg     <= '0;
            row_reg     <= '0;
            spaces_reg  <= '0;
            p_valid_reg <= 1'b0;
            p_final_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            bst_reg     <= bst_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            spaces_reg  <= spaces_next;
            p_valid_reg <= p_valid_next;
            p_final_reg <= p_final_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            code_reg <= code_step;
        end
        if (new_res)
        begin
            p_res_reg <= st_res;
        end
        if (push_now)
        begin
            o_res_reg  <= p_res_reg;
            o_last_reg <= p_final_reg;
        end
    end

    assign draw.valid       = o_valid_reg;
    assign draw.draw_op     = o_res_reg.op;
    assign draw.pos_x       = o_res_reg.x;
    assign draw.pos_y       = o_res_reg.y;
    assign draw.glyph_code  = o_res_reg.glyph;
    assign draw.ink_rgb     = o_res_reg.ink;
    assign draw.paper_rgb   = o_res_reg.paper;
    assign draw.last_of_run = o_last_reg;

endmodule

FILE: sv/text_console_cursor_engine.sv
// Text console cursor engine top level: configuration registers and the front/back pipeline.
// Steps: clear, CR and BS use the fetch step alone, LF fetch and a wrap, a printable
//   character wrap, draw and wrap, a tab four spaces; each step of the command sequencer
//   yields at most one result and, if it does, stalls while both result registers are full.
// Output: a glyph that opens the run waits for the end of the run or the next result.
// Reset: cursor at the origin, queue empty; a geometry pass follows reset and every
//   configuration write, during which transactions queue but are not executed.
module text_console_cursor_engine import tcce_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    tcce_text_if.sink         text,
    tcce_draw_if.source       draw
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    geom_t    geom;
    logic     push_valid;
    logic     push_ready;
    q_entry_t push_entry;
    logic     pop_valid;
    logic     pop_ready;
    q_entry_t pop_entry;

    // Register writes keep only the low bits that each register holds.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEFT:   cfg_next.left   = cfg_data[EDGE_IN_W-1:0];
                CFG_TOP:    cfg_next.top    = cfg_data[EDGE_IN_W-1:0];
                CFG_WIDTH:  cfg_next.width  = cfg_data[POS_W-1:0];
                CFG_HEIGHT: cfg_next.height = cfg_data[POS_W-1:0];
                CFG_SCALE:  cfg_next.scale  = cfg_data[SCALE_W-1:0];
                CFG_FORE:   cfg_next.fore   = cfg_data[RGB_W-1:0];
                CFG_BACK:   cfg_next.back   = cfg_data[RGB_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{left: RST_LEFT, top: RST_TOP, width: RST_WIDTH, height: RST_HEIGHT,
                         scale: RST_SCALE, fore: RST_FORE, back: RST_BACK};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept and classify each transaction.
    tcce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    // Decouple the classifier from the sequencer so each side stalls on its own.
    tcce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    // Region edges, cell size and last-column position; recompute on every write.
    tcce_geom u_geom (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .restart (cfg_we),
        .geom    (geom)
    );

    // Back: walk the cursor and emit drawing commands through the output register.
    tcce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop_ready (pop_ready),
        .draw      (draw)
    );

endmodule
